FILE: sv/nfa_pkg.sv
// Shared constants, types and lookup tables for the neuron forward activation block.
// Depends on nothing; imported by nfa_mac, nfa_act and neuron_forward_activation.

package nfa_pkg;

   // Fixed-point format
   localparam int FRAC_BITS = 12;
   localparam int ACC_W     = 40;
   localparam int X_W       = ACC_W - FRAC_BITS;   // floored sum width
   localparam int R_W       = X_W + 1;             // activation result before clamp
   localparam int PROD_W    = X_W + 16;            // activation-stage multiplier output
   localparam int Q16_SHIFT = 16 - FRAC_BITS;
   localparam int M16_W     = 20;                  // capped magnitude in Q16 (8.0 max)
   localparam int MODE_W    = 3;

   // Activation mode codes
   localparam logic [MODE_W-1:0] MODE_SIGMOID = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TANH    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELU    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEAKY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ELU     = 3'd4;

   // Accumulator and output limits
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [R_W-1:0]   OUT_MAX = R_W'(32767);
   localparam logic signed [R_W-1:0]   OUT_MIN = R_W'(-32768);

   // Table magnitude cap (8.0, with FRAC_BITS fraction bits) and leaky slope in Q16
   localparam logic [X_W+1:0]    MAG_CAP  = (X_W+2)'(8) << FRAC_BITS;
   localparam logic signed [15:0] LEAK_Q16 = 16'sd655;

   // Accumulator stage result handed to the activation pipeline
   typedef struct packed {
      logic                  valid;
      logic                  clip;
      logic signed [X_W-1:0] x;
   } acc_out_type;

   // Sigmoid at steps of 0.5, Q16
   function automatic logic [16:0] sig_entry(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:    v = 17'd32768;
         5'd1:    v = 17'd40793;
         5'd2:    v = 17'd47910;
         5'd3:    v = 17'd53581;
         5'd4:    v = 17'd57724;
         5'd5:    v = 17'd60565;
         5'd6:    v = 17'd62428;
         5'd7:    v = 17'd63615;
         5'd8:    v = 17'd64357;
         5'd9:    v = 17'd64816;
         5'd10:   v = 17'd65097;
         5'd11:   v = 17'd65269;
         5'd12:   v = 17'd65374;
         5'd13:   v = 17'd65438;
         5'd14:   v = 17'd65476;
         5'd15:   v = 17'd65500;
         default: v = 17'd65514;
      endcase
      return v;
   endfunction

   // exp(-t) at steps of 0.5, Q16
   function automatic logic [16:0] exp_entry(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd39749;
         5'd2:    v = 17'd24110;
         5'd3:    v = 17'd14623;
         5'd4:    v = 17'd8869;
         5'd5:    v = 17'd5380;
         5'd6:    v = 17'd3263;
         5'd7:    v = 17'd1979;
         5'd8:    v = 17'd1200;
         5'd9:    v = 17'd728;
         5'd10:   v = 17'd442;
         5'd11:   v = 17'd268;
         5'd12:   v = 17'd162;
         5'd13:   v = 17'd99;
         5'd14:   v = 17'd60;
         5'd15:   v = 17'd36;
         default: v = 17'd22;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/nfa_mac.sv
// Multiply-accumulate front end: input register, product register, saturating accumulator.
// Depends on nfa_pkg; feeds nfa_act with the floored sum of each finished fan-in.

module nfa_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 req_valid,
   input  logic signed [15:0]   req_act_in,
   input  logic signed [15:0]   req_weight,
   input  logic                 req_last,
   output nfa_pkg::acc_out_type acc_out
);
   import nfa_pkg::*;

   logic                     v1_ff;
   logic signed [15:0]       act1_ff;
   logic signed [15:0]       wgt1_ff;
   logic                     last1_ff;
   logic                     v2_ff;
   logic                     last2_ff;
   logic signed [31:0]       prod2_in;
   logic signed [31:0]       prod2_ff;
   logic signed [ACC_W:0]    sum_wide;
   logic                     over;
   logic signed [ACC_W-1:0]  clamped;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     clip_in;
   logic                     clip_ff;
   acc_out_type              acc_out_in;
   logic                     acc_valid_ff;
   logic                     acc_clip_ff;
   logic signed [X_W-1:0]    acc_x_ff;

   // Stage 1: input item register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         act1_ff  <= req_act_in;
         wgt1_ff  <= req_weight;
         last1_ff <= req_last;
      end
   end

   // Stage 2: registered product
   assign prod2_in = act1_ff * wgt1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod2_ff <= prod2_in;
         last2_ff <= last1_ff;
      end
   end

   // Stage 3: saturating accumulate; last item clears the sum and hands it on
   always_comb begin
      sum_wide = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(prod2_ff);
      over     = sum_wide[ACC_W] != sum_wide[ACC_W-1];
      if (over) begin
         clamped = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         clamped = sum_wide[ACC_W-1:0];
      end

      acc_in  = acc_ff;
      clip_in = clip_ff;
      if (v2_ff && last2_ff) begin
         acc_in  = '0;
         clip_in = 1'b0;
      end else if (v2_ff) begin
         acc_in  = clamped;
         clip_in = clip_ff | over;
      end

      acc_out_in.valid = v2_ff & last2_ff;
      acc_out_in.clip  = clip_ff | over;
      acc_out_in.x     = clamped[ACC_W-1:FRAC_BITS];   // floor to FRAC_BITS fraction bits
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         acc_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         acc_valid_ff <= acc_out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_clip_ff <= acc_out_in.clip;
         acc_x_ff    <= acc_out_in.x;
      end
   end

   assign acc_out = {acc_valid_ff, acc_clip_ff, acc_x_ff};

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && advance |=> v1_ff)
      else $error("accepted item did not reach the input register");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      advance && v2_ff && last2_ff |=> acc_ff == '0 && !clip_ff)
      else $error("accumulator not cleared after last item");

   a_no_emit_mid: assert property (@(posedge clock) disable iff (reset)
      advance && v2_ff && !last2_ff |=> !acc_valid_ff)
      else $error("sum handed on for an item without last");
`endif

endmodule

FILE: sv/nfa_act.sv
// Activation pipeline: table index/operand select, shared multiplier, combine and clamp.
// Depends on nfa_pkg; takes the floored sum from nfa_mac and owns the result register.

module nfa_act (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [nfa_pkg::MODE_W-1:0]   mode,
   input  nfa_pkg::acc_out_type         acc_res,
   output logic                         rsp_valid,
   output logic signed [15:0]           rsp_neuron_out,
   output logic                         rsp_saturated
);
   import nfa_pkg::*;

   // stage 4 comb
   logic                     neg;
   logic signed [X_W:0]      x_ext;
   logic [X_W:0]             mag;
   logic [X_W+1:0]           mag_sel;
   logic [X_W+1:0]           mag_cap;
   logic [M16_W-1:0]         m16;
   logic [4:0]               idx;
   logic [14:0]              frac;
   logic [16:0]              lo;
   logic [16:0]              hi;
   logic signed [17:0]       diff;
   logic signed [X_W-1:0]    mul_a_in;
   logic signed [15:0]       mul_b_in;
   // stage 4 registers
   logic                     v4_ff;
   logic [MODE_W-1:0]        mode4_ff;
   logic                     neg4_ff;
   logic                     sat4_ff;
   logic signed [X_W-1:0]    x4_ff;
   logic [16:0]              base4_ff;
   logic signed [X_W-1:0]    mul_a4_ff;
   logic signed [15:0]       mul_b4_ff;
   // stage 5 registers
   logic                     v5_ff;
   logic [MODE_W-1:0]        mode5_ff;
   logic                     neg5_ff;
   logic                     sat5_ff;
   logic signed [X_W-1:0]    x5_ff;
   logic [16:0]              base5_ff;
   logic signed [PROD_W-1:0] prod5_in;
   logic signed [PROD_W-1:0] prod5_ff;
   // stage 6 comb and result register
   logic signed [17:0]       y_q16;
   logic signed [18:0]       y2;
   logic signed [18:0]       t_q16;
   logic signed [17:0]       s_q16;
   logic signed [R_W-1:0]    r;
   logic signed [15:0]       out_in;
   logic                     sat_in;
   logic                     rsp_valid_ff;
   logic signed [15:0]       rsp_neuron_out_ff;
   logic                     rsp_saturated_ff;

   // Stage 4: magnitude, table index and interpolation operands
   always_comb begin
      neg   = acc_res.x[X_W-1];
      x_ext = (X_W+1)'(acc_res.x);
      mag   = neg ? unsigned'(-x_ext) : unsigned'(x_ext);
      // tanh reads the sigmoid table at twice the magnitude
      mag_sel = (mode == MODE_TANH) ? {mag, 1'b0} : {1'b0, mag};
      mag_cap = (mag_sel > MAG_CAP) ? MAG_CAP : mag_sel;
      m16     = M16_W'(mag_cap) << Q16_SHIFT;
      idx     = m16[M16_W-1:15];
      frac    = m16[14:0];

      if (mode == MODE_ELU) begin
         lo = exp_entry(idx);
         hi = (idx >= 5'd16) ? lo : exp_entry(idx + 5'd1);
      end else begin
         lo = sig_entry(idx);
         hi = (idx >= 5'd16) ? lo : sig_entry(idx + 5'd1);
      end
      diff = signed'({1'b0, hi}) - signed'({1'b0, lo});

      // one multiplier: leaky slope product, or table step times fraction
      if (mode == MODE_LEAKY) begin
         mul_a_in = acc_res.x;
         mul_b_in = LEAK_Q16;
      end else begin
         mul_a_in = X_W'(diff);
         mul_b_in = signed'({1'b0, frac});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= acc_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode4_ff  <= mode;
         neg4_ff   <= neg;
         sat4_ff   <= acc_res.clip;
         x4_ff     <= acc_res.x;
         base4_ff  <= lo;
         mul_a4_ff <= mul_a_in;
         mul_b4_ff <= mul_b_in;
      end
   end

   // Stage 5: registered multiply
   assign prod5_in = mul_a4_ff * mul_b4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode5_ff <= mode4_ff;
         neg5_ff  <= neg4_ff;
         sat5_ff  <= sat4_ff;
         x5_ff    <= x4_ff;
         base5_ff <= base4_ff;
         prod5_ff <= prod5_in;
      end
   end

   // Stage 6: finish the activation, convert Q16 back, clamp to 16 bits
   always_comb begin
      y_q16 = signed'({1'b0, base5_ff}) + 18'(prod5_ff >>> 15);
      y2    = 19'(2 * y_q16) - 19'sd65536;
      t_q16 = neg5_ff ? -y2 : y2;
      s_q16 = neg5_ff ? (18'sd65536 - y_q16) : y_q16;

      case (mode5_ff)
         MODE_TANH: begin
            r = R_W'(t_q16 >>> Q16_SHIFT);
         end
         MODE_RELU: begin
            r = neg5_ff ? '0 : R_W'(x5_ff);
         end
         MODE_LEAKY: begin
            r = neg5_ff ? R_W'(prod5_ff >>> 16) : R_W'(x5_ff);
         end
         MODE_ELU: begin
            r = neg5_ff ? R_W'((y_q16 - 18'sd65536) >>> Q16_SHIFT) : R_W'(x5_ff);
         end
         default: begin
            // sigmoid, also for the unused codes
            r = R_W'(s_q16 >>> Q16_SHIFT);
         end
      endcase

      sat_in = sat5_ff;
      if (r > OUT_MAX) begin
         out_in = 16'sh7FFF;
         sat_in = 1'b1;
      end else if (r < OUT_MIN) begin
         out_in = 16'sh8000;
         sat_in = 1'b1;
      end else begin
         out_in = r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_neuron_out_ff <= out_in;
         rsp_saturated_ff  <= sat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron_out = rsp_neuron_out_ff;
   assign rsp_saturated  = rsp_saturated_ff;

`ifndef SYNTHESIS
   a_s4_to_s5: assert property (@(posedge clock) disable iff (reset)
      advance && v4_ff |=> v5_ff)
      else $error("item lost between operand and multiply stages");

   a_s5_to_out: assert property (@(posedge clock) disable iff (reset)
      advance && v5_ff |=> rsp_valid_ff)
      else $error("item lost between multiply stage and result register");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v5_ff))
      else $error("result appeared without an item in the multiply stage");
`endif

endmodule

FILE: sv/neuron_forward_activation.sv
// Top level of the neuron forward activation block: mode register, pipeline stall control.
// Depends on nfa_pkg, nfa_mac and nfa_act.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_ready      req_act_in, req_weight, req_last
//   rsp      out        rsp_valid / rsp_ready      rsp_neuron_out, rsp_saturated
//   csr      in         csr_write_enable           csr_write_data (activation mode)
//
// One item per cycle while no result waits with rsp_ready low; the six-stage pipeline (input,
// product, accumulate, table operands, multiply, result) carries the item marked last through
// those stages in that order into the result register.
// Reset clears the accumulator, clip flag, all stage valids and sets the mode to sigmoid.
// A result held in the output register with rsp_ready low stalls every stage together,
// and req_ready stays low until that result is taken.

module neuron_forward_activation (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_act_in,
   input  logic signed [15:0]           req_weight,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [15:0]           rsp_neuron_out,
   output logic                         rsp_saturated,
   input  logic                         csr_write_enable,
   input  logic [nfa_pkg::MODE_W-1:0]   csr_write_data
);
   import nfa_pkg::*;

   logic              advance;
   logic [MODE_W-1:0] mode_ff;
   acc_out_type       acc_res;

   // Activation mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SIGMOID;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   // All stages move unless a finished result is waiting
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   nfa_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_valid  (req_valid),
      .req_act_in (req_act_in),
      .req_weight (req_weight),
      .req_last   (req_last),
      .acc_out    (acc_res)
   );

   nfa_act u_act (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .mode           (mode_ff),
      .acc_res        (acc_res),
      .rsp_valid      (rsp_valid),
      .rsp_neuron_out (rsp_neuron_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for neuron_forward_activation: drives fan-in items, predicts outputs.
// Depends on nfa_pkg (mode codes and widths) and the neuron_forward_activation RTL.

module testbench;
   import nfa_pkg::*;

   localparam int FRAC          = 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 75;
   localparam int CLAMP_RUN     = 520;

   // Mode codes the package leaves unnamed; the block treats them as sigmoid
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

   localparam logic [MODE_W-1:0] PHASE_MODES [8] = '{
      MODE_SIGMOID, MODE_UNUSED_HI, MODE_RELU, MODE_LEAKY,
      MODE_ELU, MODE_TANH, MODE_UNUSED_LO, MODE_UNUSED_MID};

   typedef enum int {SPREAD_SMALL, SPREAD_FULL, SPREAD_EXTREME} spread_type;
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_type;

   typedef struct packed {
      logic signed [15:0] neuron_out;
      logic               saturated;
   } neuron_result_type;

   // Tracks the running sum and mode, predicts each neuron output and checks it
   class scoreboard_type;
      longint            acc_sum;
      bit                clip_flag;
      logic [2:0]        mode;
      int                failures;
      neuron_result_type expected_outputs[$];
      longint            sig_q16[17];
      longint            exp_q16[17];

      function new();
         acc_sum   = 0;
         clip_flag = 0;
         mode      = MODE_SIGMOID;
         failures  = 0;
         sig_q16 = '{32768, 40793, 47910, 53581, 57724, 60565, 62428, 63615, 64357,
                     64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};
         exp_q16 = '{65536, 39749, 24110, 14623, 8869, 5380, 3263, 1979, 1200,
                     728, 442, 268, 162, 99, 60, 36, 22};
      endfunction

      function void set_mode(logic [2:0] m);
         mode = m;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // Table at half steps up to 8.0, floored linear interpolation, Q16 out
      function longint curve_q16(bit exp_curve, longint mag);
         longint m16, idx, frac, lo, hi;
         if (mag > (longint'(8) << FRAC))
            mag = longint'(8) << FRAC;
         m16 = mag << (16 - FRAC);
         idx = m16 >>> 15;
         if (idx >= 16)
            return exp_curve ? exp_q16[16] : sig_q16[16];
         lo   = exp_curve ? exp_q16[idx] : sig_q16[idx];
         hi   = exp_curve ? exp_q16[idx + 1] : sig_q16[idx + 1];
         frac = m16 & 64'h7FFF;
         return lo + (((hi - lo) * frac) >>> 15);
      endfunction

      function longint apply_activation(longint x);
         longint mag, y;
         mag = (x < 0) ? -x : x;
         case (mode)
            MODE_TANH: begin
               y = 2 * curve_q16(1'b0, 2 * mag) - 65536;
               return ((x < 0) ? -y : y) >>> (16 - FRAC);
            end
            MODE_RELU: begin
               return (x < 0) ? 0 : x;
            end
            MODE_LEAKY: begin
               return (x < 0) ? ((x * 655) >>> 16) : x;
            end
            MODE_ELU: begin
               if (x >= 0)
                  return x;
               return (curve_q16(1'b1, mag) - 65536) >>> (16 - FRAC);
            end
            default: begin
               y = curve_q16(1'b0, mag);
               return ((x < 0) ? 65536 - y : y) >>> (16 - FRAC);
            end
         endcase
      endfunction

      // One accepted input item: accumulate with clamp, predict on last
      function void absorb_item(logic signed [15:0] a, logic signed [15:0] w, logic lst);
         longint            sum, r;
         bit                sat;
         neuron_result_type res;
         sum = acc_sum + longint'(a) * longint'(w);
         if (sum > (longint'(1) << 39) - 1) begin
            sum = (longint'(1) << 39) - 1;
            clip_flag = 1;
         end else if (sum < -(longint'(1) << 39)) begin
            sum = -(longint'(1) << 39);
            clip_flag = 1;
         end
         acc_sum = sum;
         if (!lst)
            return;
         r   = apply_activation(sum >>> FRAC);
         sat = clip_flag;
         if (r > 32767) begin
            r   = 32767;
            sat = 1;
         end else if (r < -32768) begin
            r   = -32768;
            sat = 1;
         end
         res.neuron_out = r[15:0];
         res.saturated  = sat;
         expected_outputs = {expected_outputs, res};
         acc_sum   = 0;
         clip_flag = 0;
      endfunction

      function void check_output(logic signed [15:0] got_out, logic got_sat);
         neuron_result_type want;
         if (expected_outputs.size() == 0) begin
            $error("unexpected output item: neuron_out %0d, saturated %0d", got_out, got_sat);
            failures++;
            return;
         end
         want = expected_outputs.pop_front();
         if (got_out !== want.neuron_out) begin
            $error("neuron_out: expected %0d, got %0d", want.neuron_out, got_out);
            failures++;
         end
         if (got_sat !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, got_sat);
            failures++;
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic signed [15:0]   req_act_in       = '0;
   logic signed [15:0]   req_weight       = '0;
   logic                 req_last         = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic signed [15:0]   rsp_neuron_out;
   logic                 rsp_saturated;
   logic                 csr_write_enable = 1'b0;
   logic [MODE_W-1:0]    csr_write_data   = '0;

   scoreboard_type sb = new();
   int send_pct    = 0;
   int stall_pct   = 0;
   int items_sent  = 0;
   int quiet_count = 0;

   neuron_forward_activation dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_act_in       (req_act_in),
      .req_weight       (req_weight),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_neuron_out   (rsp_neuron_out),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // Monitor both channels on the edge values, plus a stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.absorb_item(req_act_in, req_weight, req_last);
         if (rsp_valid && rsp_ready)
            sb.check_output(rsp_neuron_out, rsp_saturated);
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic void set_idling(idle_type pattern);
      send_pct  = (pattern == IDLE_SENDER || pattern == IDLE_RECEIVER) ?
                  ((pattern == IDLE_SENDER) ? 87 : 0) : ((pattern == IDLE_BOTH) ? 17 : 0);
      stall_pct = (pattern == IDLE_RECEIVER) ? 87 : ((pattern == IDLE_BOTH) ? 17 : 0);
   endfunction

   function automatic logic signed [15:0] random_operand(spread_type spread);
      case (spread)
         SPREAD_SMALL: begin
            return 16'(int'($urandom_range(16383)) - 8192);
         end
         SPREAD_EXTREME: begin
            case ($urandom_range(5))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return -16'sd1;
               3:       return 16'sd0;
               4:       return 16'sd1;
               default: return 16'($urandom);
            endcase
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // Present one item and hold it until accepted
   task automatic push_item(input logic signed [15:0] a, input logic signed [15:0] w,
                            input logic lst);
      if (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_valid  <= 1'b1;
      req_act_in <= a;
      req_weight <= w;
      req_last   <= lst;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Wait until every expected output has arrived and the pipeline is empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_mode(m);
   endtask

   // One fan-in of random shape and content
   task automatic random_fanin();
      int         r, len;
      bit         neg;
      spread_type spread;
      logic signed [15:0] a, w;
      r   = $urandom_range(99);
      neg = $urandom_range(1);
      if (r < 45) begin
         len = $urandom_range(1, 8);
         spread = SPREAD_SMALL;
      end else if (r < 75) begin
         len = $urandom_range(1, 12);
         spread = SPREAD_FULL;
      end else if (r < 85) begin
         len = $urandom_range(16, 40);
         spread = SPREAD_FULL;
      end else begin
         len = $urandom_range(1, 6);
         spread = SPREAD_EXTREME;
      end
      for (int i = 0; i < len; i++) begin
         if (r >= 75 && r < 85) begin
            // heavy same-sign products push the sum far out of the table range
            a = 16'(int'($urandom_range(16384, 32767)));
            a = neg ? -a : a;
            w = 16'(int'($urandom_range(16384, 32767)));
         end else begin
            a = random_operand(spread);
            w = random_operand(spread);
         end
         push_item(a, w, i == len - 1);
      end
   endtask

   // Long fan-in of extreme products that drives the accumulator into its clamp
   task automatic clamp_fanin(input bit neg);
      for (int i = 0; i < CLAMP_RUN; i++)
         push_item(16'sh8000, neg ? 16'sh7FFF : 16'sh8000, 1'b0);
      for (int i = 0; i < 3; i++)
         push_item(16'($urandom), 16'($urandom), i == 2);
   endtask

   initial begin
      int phase_start;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed items in the reset mode (sigmoid)
      push_item(16'sd0, 16'sd0, 1'b1);
      push_item(16'sd4096, 16'sd4096, 1'b1);
      push_item(16'sh8000, 16'sh8000, 1'b1);
      push_item(16'sh8000, 16'sh7FFF, 1'b1);
      push_item(16'sd4096, 16'sd2048, 1'b0);
      push_item(-16'sd4096, 16'sd1024, 1'b0);
      push_item(16'sd8192, 16'sd4096, 1'b1);
      push_item(-16'sd1, 16'sd1, 1'b1);
      push_item(16'sh5555, 16'shAAAA, 1'b1);
      push_item(16'shAAAA, 16'sh5555, 1'b1);
      drain();

      // Other modes: a negative sum; tanh to ELU also a large positive one, clipped bar tanh
      for (int m = 1; m < 8; m++) begin
         write_mode(3'(m));
         push_item(-16'sd8192, 16'sd4096, 1'b1);
         if (3'(m) <= MODE_ELU)
            push_item(16'sh7FFF, 16'sh7FFF, 1'b1);
         drain();
      end

      // Random phases across modes and idling patterns
      for (int p = 0; p < 8; p++) begin
         set_idling(idle_type'(p % 4));
         write_mode(PHASE_MODES[p]);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            random_fanin();
         if (PHASE_MODES[p] == MODE_RELU)
            clamp_fanin(1'b0);
         if (PHASE_MODES[p] == MODE_LEAKY)
            clamp_fanin(1'b1);
         drain();
      end

      if (sb.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
